/* design/ffha_pkg.sv */
package ffha_pkg;

  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned NGRAN         = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned GW            = $clog2(NGRAN);   // granule index width
  localparam int unsigned PW            = GW + 1;          // list pointer width
  localparam int unsigned CNT_W         = 17;
  localparam int unsigned SZ_W          = 18;

  localparam logic [PW-1:0] LIST_END = PW'(NGRAN);
  localparam logic [SZ_W-1:0] SIZE_MIN = SZ_W'(32);
  localparam logic [SZ_W-1:0] SIZE_LIM = SZ_W'(HEAP_BYTES & ~32'd15);
  localparam logic [31:0] REQ_MAX = 32'hFFFF_FFF0;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_FREE = 2'd1;
  localparam logic [1:0] TAG_USED = 2'd2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]    tag;
    logic [GW-1:0] gsize;
    logic [PW-1:0] next;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

endpackage

/* design/ffha_ram.sv */
module ffha_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/first_fit_heap_allocator_core.sv */
// first-fit heap allocator with an address-ordered free list and coalescing
//
// input channel (in_valid/in_ready) takes one request word: opcode 0 allocates
// in_request_size bytes, 1 frees in_release_address, 2 rebuilds the heap from
// cfg registers heap_base and heap_size (written through cfg_we/cfg_index).
// output channel (out_valid/out_ready) returns one word per request: address,
// status and a snapshot of the usage and event counters after the request.
// block headers live in a single-port-read, single-port-write ram of 4096
// entries; one request is handled at a time.
// allocate walks the free list, one header read per block passed over, up to
// the first fit, or to its end when nothing fits; free reads and checks the
// freed header, walks the free-list blocks lying below it, links it after the
// free block below it if there is one (merging the two when they touch), and
// merges it with the next free block when that starts right after it; a free
// rejected at the header check ends there; ignored and early-rejected words go
// straight to the result; initialize runs a clearing pass over all 4096 header
// entries. in_ready returns in the cycle after the result word is loaded, so
// the free-list walk, one ram read per header, sets the rate.
// after reset the same clearing pass over all 4096 entries runs with in_ready low.
// a finished word is held in the output register; while the receiver stalls
// the next request is still taken, but its result waits until the register
// is free.
module first_fit_heap_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [31:0]                 in_request_size,
  input  logic [31:0]                 in_release_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_result_address,
  output logic [1:0]                  out_status,
  output logic [ffha_pkg::CNT_W-1:0]  out_bytes_in_use,
  output logic [ffha_pkg::CNT_W-1:0]  out_bytes_free,
  output logic [ffha_pkg::CNT_W-1:0]  out_peak_in_use,
  output logic [31:0]                 out_allocations_done,
  output logic [31:0]                 out_releases_done,
  output logic [31:0]                 out_failures_seen,
  output logic [ffha_pkg::CNT_W-1:0]  out_bytes_total
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_CHK, S_A_DAT, S_A_WCUR, S_A_LINK,
    S_F_RDC, S_F_CHKC, S_F_WLK, S_F_WDAT, S_F_W1, S_F_W2,
    S_F_NCHK, S_F_NDAT, S_DONE
  } state_t;

  state_t state_r;

  // configuration and latched heap geometry
  logic [31:0]      heap_base_r;
  logic [CNT_W-1:0] heap_size_r;
  logic [31:0]      lat_base_r;
  logic [CNT_W-1:0] lat_size_r;
  logic             ready_r;
  logic [PW-1:0]    head_r;

  // statistics
  logic [CNT_W-1:0] used_r, free_r, peak_r, total_r;
  logic [31:0]      allocs_r, frees_r, fails_r;

  // working registers
  logic [31:0]   req_r;
  logic [GW-1:0] clr_r;
  logic          init_r;
  logic [PW-1:0] cur_r, prev_r, hn_r, guard_r;
  hdr_t          prevh_r;
  logic [GW-1:0] g_r, gs_r, csz_r, cg_r;
  logic [GW:0]   cs_r;
  logic [31:0]   res_addr_r;
  logic [1:0]    res_st_r;

  // output register
  logic             out_valid_r;
  logic [31:0]      out_addr_r;
  logic [1:0]       out_st_r;
  logic [CNT_W-1:0] out_used_r, out_free_r, out_peak_r, out_total_r;
  logic [31:0]      out_allocs_r, out_frees_r, out_fails_r;

  // header ram ports
  logic          ram_we;
  logic [GW-1:0] ram_waddr, ram_raddr;
  hdr_t          ram_wdata, rd;
  logic [HDR_W-1:0] ram_rdata;

  ffha_ram #(.DW(HDR_W), .DEPTH(NGRAN)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = hdr_t'(ram_rdata);

  // request size in granules, and fit test against the header just read
  logic [32:0]   req_sum;
  logic [28:0]   need;
  logic [29:0]   gsz_ext;
  logic          fits, split;
  logic [PW-1:0] rest;

  assign req_sum = {1'b0, req_r} + 33'd15;
  assign need    = req_sum[32:4];
  assign gsz_ext = 30'(rd.gsize);
  assign fits    = gsz_ext >= ({1'b0, need} + 30'd1);
  assign split   = gsz_ext >= ({1'b0, need} + 30'd2);
  assign rest    = cur_r + PW'(1) + need[PW-1:0];

  // free address check, done on the incoming word
  logic [31:0] off;
  logic        free_bad;
  assign off      = in_release_address - lat_base_r - 32'd16;
  assign free_bad = !ready_r || (off >= 32'(lat_size_r)) || (off[3:0] != 4'd0);

  // initialize geometry from configuration
  logic [SZ_W-1:0] sz_round, sz_clamp;
  logic [GW-1:0]   init_gsize;
  assign sz_round   = ({1'b0, heap_size_r} + SZ_W'(15)) & ~SZ_W'(15);
  assign sz_clamp   = (sz_round < SIZE_MIN) ? SIZE_MIN :
                      (sz_round > SIZE_LIM) ? SIZE_LIM : sz_round;
  assign init_gsize = GW'(sz_clamp[SZ_W-1:4] - 14'd1);

  // merge helpers on the free path
  logic          merged;
  logic [GW:0]   cs_new;
  logic [PW:0]   cend;
  assign merged = (prev_r != LIST_END) &&
                  ((prev_r + PW'(1) + PW'(prevh_r.gsize)) == PW'(g_r));
  assign cs_new = merged ? ((GW+1)'(prevh_r.gsize) + (GW+1)'(1) + (GW+1)'(csz_r))
                         : (GW+1)'(csz_r);
  assign cend   = (PW+1)'(cg_r) + (PW+1)'(1) + (PW+1)'(cs_r);

  logic [CNT_W-1:0] gs_bytes, csz_bytes, used_after;
  assign gs_bytes   = CNT_W'({gs_r, 4'd0});
  assign csz_bytes  = CNT_W'({rd.gsize, 4'd0});
  assign used_after = used_r + gs_bytes;

  assign in_ready = (state_r == S_IDLE);

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_r[GW-1:0];
    ram_wdata = '0;
    ram_raddr = cur_r[GW-1:0];
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (init_r && clr_r == '0) begin
          ram_wdata = '{tag: TAG_FREE, gsize: total_r[GW+3:4], next: LIST_END};
        end
      end
      S_A_DAT: begin
        ram_we    = fits && split && (rest < LIST_END);
        ram_waddr = rest[GW-1:0];
        ram_wdata = '{tag: TAG_FREE, gsize: GW'(rd.gsize - need[GW-1:0] - GW'(1)),
                      next: rd.next};
      end
      S_A_WCUR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r[GW-1:0];
        ram_wdata = '{tag: TAG_USED, gsize: gs_r, next: hn_r};
      end
      S_A_LINK: begin
        ram_we    = (prev_r != LIST_END);
        ram_waddr = prev_r[GW-1:0];
        ram_wdata = '{tag: prevh_r.tag, gsize: prevh_r.gsize, next: hn_r};
      end
      S_F_RDC: ram_raddr = g_r;
      S_F_W1: begin
        ram_we    = 1'b1;
        ram_waddr = g_r;
        ram_wdata = '{tag: TAG_FREE, gsize: csz_r, next: cur_r};
      end
      S_F_W2: begin
        ram_we    = 1'b1;
        ram_waddr = prev_r[GW-1:0];
        if (cg_r == prev_r[GW-1:0] && cg_r != g_r) begin
          ram_wdata = '{tag: prevh_r.tag, gsize: cs_r[GW-1:0], next: cur_r};
        end else begin
          ram_wdata = '{tag: prevh_r.tag, gsize: prevh_r.gsize, next: PW'(g_r)};
        end
      end
      S_F_NDAT: begin
        ram_we    = (rd.tag == TAG_FREE);
        ram_waddr = cg_r;
        ram_wdata = '{tag: TAG_FREE,
                      gsize: GW'(cs_r + (GW+1)'(1) + (GW+1)'(rd.gsize)),
                      next: rd.next};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      init_r      <= 1'b0;
      heap_base_r <= '0;
      heap_size_r <= CNT_W'(65536);
      lat_base_r  <= '0;
      lat_size_r  <= '0;
      ready_r     <= 1'b0;
      head_r      <= LIST_END;
      used_r      <= '0;
      free_r      <= '0;
      peak_r      <= '0;
      total_r     <= '0;
      allocs_r    <= '0;
      frees_r     <= '0;
      fails_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE: heap_base_r <= cfg_wdata;
          CFG_SIZE: heap_size_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // a word leaving while the next one loads is handled in S_DONE
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        // clearing pass over every header; on initialize the initial block is written at 0
        S_CLR: begin
          clr_r <= clr_r + GW'(1);
          if (clr_r == GW'(NGRAN - 1)) begin
            state_r <= init_r ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            req_r    <= in_request_size;
            res_addr_r <= '0;
            res_st_r <= ST_DONE;
            cur_r    <= head_r;
            prev_r   <= LIST_END;
            guard_r  <= '0;
            state_r  <= S_DONE;
            unique case (in_opcode)
              OP_ALLOC: begin
                if (!ready_r || in_request_size == '0) begin
                  res_st_r <= ST_IGNORED;
                end else if (in_request_size > REQ_MAX) begin
                  res_st_r <= ST_NOFIT;
                  fails_r  <= fails_r + 32'd1;
                end else begin
                  state_r <= S_A_CHK;
                end
              end
              OP_FREE: begin
                if (in_release_address == '0) begin
                  res_st_r <= ST_IGNORED;
                end else if (free_bad) begin
                  res_st_r <= ST_BADFREE;
                  fails_r  <= fails_r + 32'd1;
                end else begin
                  g_r     <= off[GW+3:4];
                  state_r <= S_F_RDC;
                end
              end
              OP_INIT: begin
                lat_base_r <= (heap_base_r + 32'd15) & ~32'd15;
                lat_size_r <= CNT_W'(sz_clamp);
                total_r    <= CNT_W'({init_gsize, 4'd0});
                free_r     <= CNT_W'({init_gsize, 4'd0});
                used_r     <= '0;
                head_r     <= '0;
                ready_r    <= 1'b1;
                init_r     <= 1'b1;
                clr_r      <= '0;
                state_r    <= S_CLR;
              end
              default: res_st_r <= ST_IGNORED;
            endcase
          end
        end

        // allocate: first-fit walk, one header read per step
        S_A_CHK: begin
          if (cur_r < LIST_END && guard_r < PW'(NGRAN)) begin
            state_r <= S_A_DAT;
          end else begin
            res_st_r <= ST_NOFIT;
            fails_r  <= fails_r + 32'd1;
            state_r  <= S_DONE;
          end
        end
        S_A_DAT: begin
          if (fits) begin
            if (split && rest < LIST_END) begin
              hn_r <= rest;
              gs_r <= need[GW-1:0];
            end else begin
              hn_r <= rd.next;
              gs_r <= rd.gsize;
            end
            state_r <= S_A_WCUR;
          end else begin
            prev_r  <= cur_r;
            prevh_r <= rd;
            cur_r   <= rd.next;
            guard_r <= guard_r + PW'(1);
            state_r <= S_A_CHK;
          end
        end
        S_A_WCUR: state_r <= S_A_LINK;
        S_A_LINK: begin
          if (prev_r == LIST_END) begin
            head_r <= hn_r;
          end
          used_r     <= used_after;
          free_r     <= free_r - gs_bytes;
          allocs_r   <= allocs_r + 32'd1;
          if (used_after > peak_r) begin
            peak_r <= used_after;
          end
          res_addr_r <= lat_base_r + 32'({cur_r[GW-1:0], 4'd0}) + 32'd16;
          res_st_r   <= ST_DONE;
          state_r    <= S_DONE;
        end

        // free: check the header, find the insertion point, then link and merge
        S_F_RDC: state_r <= S_F_CHKC;
        S_F_CHKC: begin
          if (rd.tag != TAG_USED) begin
            res_st_r <= ST_BADFREE;
            fails_r  <= fails_r + 32'd1;
            state_r  <= S_DONE;
          end else begin
            csz_r   <= rd.gsize;
            used_r  <= used_r - csz_bytes;
            free_r  <= free_r + csz_bytes;
            frees_r <= frees_r + 32'd1;
            state_r <= S_F_WLK;
          end
        end
        S_F_WLK: begin
          if (cur_r < LIST_END && cur_r < PW'(g_r) && guard_r < PW'(NGRAN)) begin
            state_r <= S_F_WDAT;
          end else begin
            state_r <= S_F_W1;
          end
        end
        S_F_WDAT: begin
          prev_r  <= cur_r;
          prevh_r <= rd;
          cur_r   <= rd.next;
          guard_r <= guard_r + PW'(1);
          state_r <= S_F_WLK;
        end
        S_F_W1: begin
          if (prev_r == LIST_END) begin
            head_r <= PW'(g_r);
          end
          cg_r    <= merged ? prev_r[GW-1:0] : g_r;
          cs_r    <= cs_new;
          state_r <= (prev_r == LIST_END) ? S_F_NCHK : S_F_W2;
        end
        S_F_W2: state_r <= S_F_NCHK;
        S_F_NCHK: begin
          if (cur_r < LIST_END && cend == (PW+1)'(cur_r)) begin
            state_r <= S_F_NDAT;
          end else begin
            res_st_r <= ST_DONE;
            state_r  <= S_DONE;
          end
        end
        S_F_NDAT: begin
          res_st_r <= ST_DONE;
          state_r  <= S_DONE;
        end

        // result word waits here until the output register is free
        S_DONE: begin
          init_r <= 1'b0;
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_addr_r   <= res_addr_r;
            out_st_r     <= res_st_r;
            out_used_r   <= used_r;
            out_free_r   <= free_r;
            out_peak_r   <= peak_r;
            out_total_r  <= total_r;
            out_allocs_r <= allocs_r;
            out_frees_r  <= frees_r;
            out_fails_r  <= fails_r;
            state_r      <= S_IDLE;
          end else if (out_valid_r && out_ready) begin
            out_valid_r  <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ram read address while walking is cur_r; the read of the freed header
  // and of the right neighbour also come from cur_r/g_r above

  assign out_valid            = out_valid_r;
  assign out_result_address   = out_addr_r;
  assign out_status           = out_st_r;
  assign out_bytes_in_use     = out_used_r;
  assign out_bytes_free       = out_free_r;
  assign out_peak_in_use      = out_peak_r;
  assign out_bytes_total      = out_total_r;
  assign out_allocations_done = out_allocs_r;
  assign out_releases_done    = out_frees_r;
  assign out_failures_seen    = out_fails_r;

  // used and free bytes always add up to the capacity
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(used_r + free_r) == total_r)
    else $error("used plus free differs from total");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= used_r)
    else $error("peak below bytes in use");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_no_alloc_unready: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |=> $stable(allocs_r))
    else $error("allocation counted before initialize");

endmodule
